// ----- rtl/qta_pkg.sv -----
// ----------------------------------------------------------------------------
// qta_pkg: shared types and constants of the quaternion transform accumulator
// Command and result word layouts, opcode codes, Hamilton product term tables.
// ----------------------------------------------------------------------------
package qta_pkg;

    // Width of the operand and result fields on the channels
    localparam int QTA_IO_WIDTH   = 32;
    // Default fixed-point format of the stored components
    localparam int QTA_FRAC_BITS  = 16;
    localparam int QTA_COMP_WIDTH = 32;
    // Components w, x, y, z
    localparam int QTA_LANES      = 4;

    // 2*pi with 32 fraction bits
    localparam logic [63:0] QTA_TWO_PI_Q32 = 64'h0000_0006_487E_D511;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QMUL  = 2'd1,
        OP_SCALE = 2'd2,
        OP_EULER = 2'd3
    } qta_opcode_t;

    // Hamilton product v*q: component k sums v[j] * q[QTA_TERM_IDX[k][j]],
    // negated where bit j of QTA_TERM_NEG[k] is set
    localparam logic [1:0] QTA_TERM_IDX [QTA_LANES][QTA_LANES] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd3, 2'd2, 2'd1, 2'd0}
    };
    localparam logic [QTA_LANES-1:0] QTA_TERM_NEG [QTA_LANES] = '{
        4'b1110, 4'b1000, 4'b0010, 4'b0100
    };

    typedef struct packed {
        qta_opcode_t                    opcode;
        logic signed [QTA_IO_WIDTH-1:0] op_w;
        logic signed [QTA_IO_WIDTH-1:0] op_x;
        logic signed [QTA_IO_WIDTH-1:0] op_y;
        logic signed [QTA_IO_WIDTH-1:0] op_z;
    } qta_cmd_t;

    typedef struct packed {
        logic signed [QTA_IO_WIDTH-1:0] out_w;
        logic signed [QTA_IO_WIDTH-1:0] out_x;
        logic signed [QTA_IO_WIDTH-1:0] out_y;
        logic signed [QTA_IO_WIDTH-1:0] out_z;
        logic                           saturated;
    } qta_res_t;

endpackage

// ----- rtl/qta_if.sv -----
// ----------------------------------------------------------------------------
// qta_if: command and result channels
// Valid/ready channels carrying one command word or one result word.
// ----------------------------------------------------------------------------
interface qta_cmd_if
    import qta_pkg::*;
();
    logic     valid;
    logic     ready;
    qta_cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qta_res_if
    import qta_pkg::*;
();
    logic     valid;
    logic     ready;
    qta_res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/qta_datapath.sv -----
// ----------------------------------------------------------------------------
// qta_datapath: next-state logic of the accumulator
// Saturating add, Hamilton product, xyz scale and wrapped euler add.
// ----------------------------------------------------------------------------
module qta_datapath
    import qta_pkg::*;
#(
    parameter int FRAC_BITS  = QTA_FRAC_BITS,
    parameter int COMP_WIDTH = QTA_COMP_WIDTH
)(
    input  qta_cmd_t                     cmd,
    input  logic signed [COMP_WIDTH-1:0] state      [QTA_LANES],
    output logic signed [COMP_WIDTH-1:0] state_next [QTA_LANES],
    output logic                         saturated
);

    localparam int W   = COMP_WIDTH;
    localparam int PW  = 2 * W;
    localparam int SW  = 2 * W + 2;
    localparam int IOW = QTA_IO_WIDTH;
    localparam int MW  = ((W > FRAC_BITS + 3) ? W : FRAC_BITS + 3) + 1;

    localparam logic [63:0] TWO_PI_WIDE =
        (QTA_TWO_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic [MW-1:0] TWO_PI     = MW'(TWO_PI_WIDE);
    localparam logic [63:0]   RECIP_WIDE = (64'd1 << (W - 1)) / TWO_PI_WIDE;
    localparam logic [W-1:0]  RECIP      = W'(RECIP_WIDE);

    localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

    // {clamped, value}
    function automatic logic [W:0] sat_sum(input logic signed [W-1:0] a,
                                           input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
            return {1'b1, (s[W] ? MIN_VAL : MAX_VAL)};
        return {1'b0, s[W-1:0]};
    endfunction

    // drop the fraction bits (floor), then clamp to the component range
    function automatic logic [W:0] finish(input logic signed [SW-1:0] acc);
        logic signed [SW-1:0] sh;
        logic [SW-W:0]        top;
        sh  = acc >>> FRAC_BITS;
        top = sh[SW-1:W-1];
        if ((&top) || !(|top))
            return {1'b0, sh[W-1:0]};
        return {1'b1, (sh[SW-1] ? MIN_VAL : MAX_VAL)};
    endfunction

    logic signed [IOW-1:0] raw   [QTA_LANES];
    logic signed [W-1:0]   op    [QTA_LANES];
    logic signed [SW-1:0]  terms [QTA_LANES][QTA_LANES];
    logic signed [PW-1:0]  diag  [QTA_LANES];
    logic signed [SW-1:0]  acc   [QTA_LANES];
    logic [QTA_LANES-1:0]  sat_lane;

    assign raw[0] = cmd.op_w;
    assign raw[1] = cmd.op_x;
    assign raw[2] = cmd.op_y;
    assign raw[3] = cmd.op_z;

    for (genvar k = 0; k < QTA_LANES; k++) begin : g_op
        if (W >= IOW) begin : g_ext
            assign op[k] = W'(raw[k]);
        end else begin : g_clamp
            logic fits;
            assign fits  = (&raw[k][IOW-1:W-1]) || !(|raw[k][IOW-1:W-1]);
            assign op[k] = fits ? raw[k][W-1:0] : (raw[k][IOW-1] ? MIN_VAL : MAX_VAL);
        end
    end

    // Multiply array; the diagonal multipliers double as the xyz scalers
    for (genvar k = 0; k < QTA_LANES; k++) begin : g_row
        for (genvar j = 0; j < QTA_LANES; j++) begin : g_col
            logic signed [W-1:0]  mul_b;
            logic signed [PW-1:0] prod;
            assign mul_b = (j == k && cmd.opcode == OP_SCALE) ? op[k]
                                                              : op[QTA_TERM_IDX[k][j]];
            assign prod  = PW'(state[j]) * PW'(mul_b);
            assign terms[k][j] = QTA_TERM_NEG[k][j] ? -SW'(prod) : SW'(prod);
            if (j == k) begin : g_diag
                assign diag[k] = prod;
            end
        end
        assign acc[k] = terms[k][0] + terms[k][1] + terms[k][2] + terms[k][3];
    end

    for (genvar k = 0; k < QTA_LANES; k++) begin : g_lane
        logic [W:0] add_r;
        logic [W:0] ham_r;
        logic [W:0] lane_r;

        assign add_r = sat_sum(state[k], op[k]);
        assign ham_r = finish(acc[k]);

        if (k == 0) begin : g_w
            always_comb
            begin
                case (cmd.opcode)
                    OP_ADD:  lane_r = add_r;
                    OP_QMUL: lane_r = ham_r;
                    default: lane_r = {1'b0, state[k]};
                endcase
            end
        end else begin : g_xyz
            logic [W:0]           scl_r;
            logic signed [W-1:0]  add_v;
            logic signed [MW-1:0] sum_ext;
            logic [W-2:0]         mag;
            logic [2*W-2:0]       q_prod;
            logic [W-1:0]         q_est;
            logic [MW-1:0]        q_mul;
            logic [MW-1:0]        rem0;
            logic [MW-1:0]        rem1;
            logic signed [W-1:0]  wrp_v;

            assign scl_r   = finish(SW'(diag[k]));
            assign add_v   = add_r[W-1:0];
            assign sum_ext = MW'(add_v);
            assign mag     = add_v[W-2:0];
            // reciprocal estimate of the quotient is low by at most one
            assign q_prod  = (2*W-1)'(mag) * (2*W-1)'(RECIP);
            assign q_est   = q_prod[2*W-2:W-1];
            assign q_mul   = MW'(q_est) * TWO_PI;
            assign rem0    = MW'(mag) - q_mul;
            assign rem1    = (rem0 >= TWO_PI) ? rem0 - TWO_PI : rem0;
            assign wrp_v   = (sum_ext > $signed(TWO_PI)) ? W'(rem1) : add_v;

            always_comb
            begin
                case (cmd.opcode)
                    OP_ADD:   lane_r = add_r;
                    OP_QMUL:  lane_r = ham_r;
                    OP_SCALE: lane_r = scl_r;
                    OP_EULER: lane_r = {add_r[W], wrp_v};
                    default:  lane_r = {1'b0, state[k]};
                endcase
            end
        end

        assign state_next[k] = lane_r[W-1:0];
        assign sat_lane[k]   = lane_r[W];
    end

    assign saturated = |sat_lane;

endmodule

// ----- rtl/quaternion_transform_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// quaternion_transform_accumulator_core: Q-format w,x,y,z accumulator
// Path: a command passes the input register, then the result register, before its result is valid.
// Throughput: 1 word per cycle while res.ready holds; set by the state feedback loop.
// Reset: rst_n clears the vector to zero and empties both registers.
// ----------------------------------------------------------------------------
module quaternion_transform_accumulator_core
    import qta_pkg::*;
#(
    parameter int FRAC_BITS  = QTA_FRAC_BITS,
    parameter int COMP_WIDTH = QTA_COMP_WIDTH
)(
    input  logic      clk,
    input  logic      rst_n,
    qta_cmd_if.sink   cmd,
    qta_res_if.source res
);

    // Stage 1 holds the accepted command word. Stage 2 is the result
    // register; the vector state updates in the same edge, so each command
    // sees the vector left by the one before it. While a finished result
    // waits on the output, the input register takes a word only if it is empty.

    // Low result-field bits of a component (sign extended when narrower)
    function automatic logic signed [QTA_IO_WIDTH-1:0] to_io(
        input logic signed [COMP_WIDTH-1:0] v);
        return QTA_IO_WIDTH'(v);
    endfunction

    logic                         in_valid_reg;
    qta_cmd_t                     in_data_reg;
    logic signed [COMP_WIDTH-1:0] state_reg  [QTA_LANES];
    logic signed [COMP_WIDTH-1:0] state_next [QTA_LANES];
    logic                         sat_next;
    logic                         res_valid_reg;
    qta_res_t                     res_data_reg;
    logic                         advance;

    qta_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .COMP_WIDTH (COMP_WIDTH)
    ) u_datapath (
        .cmd        (in_data_reg),
        .state      (state_reg),
        .state_next (state_next),
        .saturated  (sat_next)
    );

    // Move the held command into the result register when the output slot
    // is empty or being drained this cycle
    assign advance   = in_valid_reg && (!res_valid_reg || res.ready);
    // Take a new word whenever the input register is free or moving on
    assign cmd.ready = !in_valid_reg || advance;

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < QTA_LANES; k++)
            begin
                state_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on accept / advance, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_data_reg <= cmd.data;
        end
        if (advance)
        begin
            res_data_reg.out_w     <= to_io(state_next[0]);
            res_data_reg.out_x     <= to_io(state_next[1]);
            res_data_reg.out_y     <= to_io(state_next[2]);
            res_data_reg.out_z     <= to_io(state_next[3]);
            res_data_reg.saturated <= sat_next;
        end
    end

`ifndef SYNTHESIS
    // The shown result always matches the vector it was taken from
    a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_data_reg.out_w == to_io(state_reg[0]))
                       && (res_data_reg.out_x == to_io(state_reg[1]))
                       && (res_data_reg.out_y == to_io(state_reg[2]))
                       && (res_data_reg.out_z == to_io(state_reg[3])))
        else $error("result register out of step with vector state");

    // The vector changes only when a command moves into the result register
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg[0]) && $stable(state_reg[1])
                  && $stable(state_reg[2]) && $stable(state_reg[3]))
        else $error("vector state changed without an update");

    // A held command is never overwritten while the output is blocked
    a_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("pending command lost while output stalled");
`endif

endmodule
